FILE: rtl/scws_pkg.sv
// ============================================================================
// scws_pkg
// Shared types, character codes and step functions for the script
// comment and whitespace stripper.
// ============================================================================
package scws_pkg;

    // Character codes
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Result queue depth
    localparam int unsigned QDEPTH = 3;

    typedef enum logic [1:0] {
        MODE_CODE    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_STRING  = 2'd2
    } scws_mode_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_stream;
    } scws_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       no_char;
        logic       last_result;
    } scws_out_t;

    typedef struct packed {
        scws_mode_t mode;
        logic       quote_single;
        logic       bs_odd;
        logic       dash_pend;
        logic [7:0] prev;
        logic       empty;
    } scws_state_t;

    // Working record of one step: running state plus emitted bytes
    typedef struct packed {
        scws_state_t st;
        logic [1:0]  cnt;
        logic [7:0]  ch0;
        logic [7:0]  ch1;
    } scws_step_t;

    // Core to queue handoff
    typedef struct packed {
        logic [1:0] cnt;
        scws_out_t  res0;
        scws_out_t  res1;
    } scws_push_t;

    localparam scws_state_t ST_RESET = '{
        mode:         MODE_CODE,
        quote_single: 1'b0,
        bs_odd:       1'b0,
        dash_pend:    1'b0,
        prev:         8'h00,
        empty:        1'b1
    };

    // Append one byte to the step record and track it as last output
    function automatic scws_step_t put_char(scws_step_t s, logic [7:0] c);
        scws_step_t r;
        r = s;
        if (s.cnt == 2'd0) begin
            r.ch0 = c;
        end else begin
            r.ch1 = c;
        end
        r.cnt      = s.cnt + 2'd1;
        r.st.prev  = c;
        r.st.empty = 1'b0;
        return r;
    endfunction

    // Handle one byte as code, with no dash pending on entry
    function automatic scws_step_t code_char(scws_step_t s, logic [7:0] c);
        scws_step_t r;
        r = s;
        if (c inside {CH_DQUOTE, CH_SQUOTE}) begin
            r.st.mode         = MODE_STRING;
            r.st.quote_single = (c == CH_SQUOTE);
            r.st.bs_odd       = 1'b0;
            r = put_char(r, c);
        end else if (c == CH_DASH) begin
            r.st.dash_pend = 1'b1;
        end else if (c inside {CH_SPACE, CH_TAB}) begin
            if (!s.st.empty && s.st.prev != CH_SPACE && s.st.prev != CH_LF) begin
                r = put_char(r, CH_SPACE);
            end
        end else if (c inside {CH_LF, CH_CR}) begin
            if (!s.st.empty && s.st.prev != CH_LF) begin
                r = put_char(r, CH_LF);
            end
        end else begin
            r = put_char(r, c);
        end
        return r;
    endfunction

endpackage

FILE: rtl/scws_core.sv
// ============================================================================
// scws_core
// Scanner state and per-character step logic. Turns one character into
// zero, one or two result beats through combinational step logic.
// ============================================================================
module scws_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  scws_pkg::scws_in_t    item,
    output scws_pkg::scws_push_t push
);
    import scws_pkg::*;

    scws_state_t st_reg;
    scws_state_t st_next;
    scws_step_t  stp;
    logic [7:0]  quote_ch;

    // Step the scanner on the held character
    always_comb begin
        stp.st   = st_reg;
        stp.cnt  = 2'd0;
        stp.ch0  = 8'h00;
        stp.ch1  = 8'h00;
        quote_ch = st_reg.quote_single ? CH_SQUOTE : CH_DQUOTE;

        case (st_reg.mode)
            MODE_COMMENT: begin
                if (item.in_char inside {CH_LF, CH_CR}) begin
                    stp.st.mode = MODE_CODE;
                    stp = put_char(stp, CH_LF);
                end
            end
            MODE_STRING: begin
                stp = put_char(stp, item.in_char);
                if (item.in_char == quote_ch && !st_reg.bs_odd) begin
                    stp.st.mode = MODE_CODE;
                end
                stp.st.bs_odd = (item.in_char == CH_BSLASH) ? ~st_reg.bs_odd : 1'b0;
            end
            default: begin
                stp.st.mode = MODE_CODE;
                if (st_reg.dash_pend) begin
                    stp.st.dash_pend = 1'b0;
                    if (item.in_char == CH_DASH) begin
                        stp.st.mode = MODE_COMMENT;
                    end else begin
                        stp = put_char(stp, CH_DASH);
                        stp = code_char(stp, item.in_char);
                    end
                end else begin
                    stp = code_char(stp, item.in_char);
                end
            end
        endcase

        // Flush a pending dash at end of stream
        if (item.end_of_stream && stp.st.dash_pend) begin
            stp.st.dash_pend = 1'b0;
            stp = put_char(stp, CH_DASH);
        end
    end

    // Build result beats and the next state
    always_comb begin
        push.res0 = '{out_char: stp.ch0, no_char: 1'b0, last_result: 1'b0};
        push.res1 = '{out_char: stp.ch1, no_char: 1'b0, last_result: 1'b0};
        push.cnt  = stp.cnt;
        st_next   = stp.st;
        if (item.end_of_stream) begin
            st_next = ST_RESET;
            case (stp.cnt)
                2'd0: begin
                    push.cnt  = 2'd1;
                    push.res0 = '{out_char: 8'h00, no_char: 1'b1, last_result: 1'b1};
                end
                2'd1: push.res0.last_result = 1'b1;
                default: push.res1.last_result = 1'b1;
            endcase
        end
        if (!fire) begin
            push.cnt = 2'd0;
        end
    end

    // Advance state on each processed character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_RESET;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.end_of_stream |=> st_reg.mode == MODE_CODE && st_reg.empty
            && !st_reg.dash_pend)
        else $error("state not cleared after end of stream");

    a_last_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.end_of_stream |-> push.cnt != 2'd0)
        else $error("end of stream produced no result beat");

endmodule

FILE: rtl/scws_outq.sv
// ============================================================================
// scws_outq
// Three-entry result queue. Takes up to two beats per cycle while it has
// room, presents one beat per cycle on the result channel while m_ready is high.
// ============================================================================
module scws_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  scws_pkg::scws_push_t  push,
    output logic                  room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output scws_pkg::scws_out_t   m_payload
);
    import scws_pkg::*;

    scws_out_t  q_reg  [QDEPTH];
    scws_out_t  q_next [QDEPTH];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] base;
    logic       pop;

    assign m_valid   = (count_reg != 2'd0);
    assign m_payload = q_reg[0];
    assign pop       = m_valid && m_ready;
    // Room for a two-beat push regardless of the receiver
    assign room      = (count_reg <= 2'd1);

    // Shift out the head, then append new beats behind the survivors
    always_comb begin
        q_next = q_reg;
        base   = count_reg;
        if (pop) begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            base      = count_reg - 2'd1;
        end
        if (push.cnt != 2'd0) begin
            q_next[base] = push.res0;
        end
        if (push.cnt == 2'd2) begin
            q_next[base + 2'd1] = push.res1;
        end
        count_next = base + push.cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt != 2'd0 |-> room)
        else $error("push into a full result queue");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && push.cnt == 2'd0 |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count wrong after pop");

endmodule

FILE: rtl/script_comment_whitespace_stripper_top.sv
// ============================================================================
// script_comment_whitespace_stripper_top
// Script minifier: strips line comments and collapses whitespace, one
// character per beat.
// ============================================================================
// Usage:
//   Input channel s_*: one script character per beat, with end_of_stream
//   set on the final character. Result channel m_*: one emitted character
//   per beat; no_char marks a beat that carries only the end marker, and
//   last_result marks the final beat of a script.
//   Each input character yields zero, one or two result beats.
//   An accepted character is held in the input register, then stepped and
//   written to the queue once the queue has room, so its first result shows
//   on m_valid from the queue (input register, then step and queue write).
//   Throughput: one character per cycle while characters give at most one
//   result and the receiver keeps up; a two-result character needs two beats
//   on the single-beat read port of the three-entry result queue.
//   Reset (aresetn low, synchronous) empties the input register and the
//   queue and returns the scanner to code mode with no output seen; the
//   same scanner reset happens after every end_of_stream character.
//   When the receiver stalls, the queue fills; s_ready drops once the input
//   register holds a character that the queue has no room for.
// ============================================================================
module script_comment_whitespace_stripper_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  scws_pkg::scws_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output scws_pkg::scws_out_t m_payload
);
    import scws_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    scws_in_t   in_data_reg;
    logic       room;
    logic       take;
    scws_push_t push;

    // Process the held character when the queue can absorb two beats
    assign take    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the input beat
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_payload;
        end
    end

    scws_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (take),
        .item    (in_data_reg),
        .push    (push)
    );

    scws_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
